@@ hw/rtl/grid_mesh_edge_triangle_indexer_defines.svh @@
// Assertion macros used by the grid mesh indexer top level.
`ifndef GRID_MESH_EDGE_TRIANGLE_INDEXER_DEFINES_SVH
`define GRID_MESH_EDGE_TRIANGLE_INDEXER_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define GMETI_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("gmeti check failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define GMETI_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("gmeti check failed");

`endif

@@ hw/rtl/gmeti_pkg.sv @@
// Shared constants, codes and result type of the grid mesh indexer.
package gmeti_pkg;

  localparam int IDX_W       = 18;
  localparam int CFG_W       = 9;
  localparam int CFG_ADDR_W  = 8;
  localparam int MAX_DIM_DEF = 256;

  localparam logic [CFG_W-1:0] CFG_DIM_RESET = CFG_W'(128);

  localparam logic [CFG_ADDR_W-1:0] REG_GRID_WIDTH  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_HEIGHT = CFG_ADDR_W'(1);

  localparam logic [2:0] PH_HORIZ  = 3'd0;
  localparam logic [2:0] PH_VERT   = 3'd1;
  localparam logic [2:0] PH_DIAG   = 3'd2;
  localparam logic [2:0] PH_BOTTOM = 3'd3;
  localparam logic [2:0] PH_TRI    = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  typedef struct packed {
    logic             valid_res;
    logic             kind;
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
    logic [IDX_W-1:0] idx_c;
    logic             last;
  } gmeti_res_t;

endpackage

@@ hw/rtl/gmeti_if.sv @@
// Channel interfaces of the grid mesh indexer: request, result and register write.
interface gmeti_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface gmeti_out_if import gmeti_pkg::*;;
  logic             valid;
  logic             ready;
  logic             valid_res;
  logic             kind;
  logic [IDX_W-1:0] idx_a;
  logic [IDX_W-1:0] idx_b;
  logic [IDX_W-1:0] idx_c;
  logic             last;

  modport source (output valid, output valid_res, output kind, output idx_a,
                  output idx_b, output idx_c, output last, input ready);
  modport sink (input valid, input valid_res, input kind, input idx_a,
                input idx_b, input idx_c, input last, output ready);
endinterface

interface gmeti_cfg_if import gmeti_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_W-1:0]      data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

@@ hw/rtl/gmeti_step.sv @@
// Next-element logic: current walk position to emitted element and next position.
module gmeti_step import gmeti_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF,
  parameter int DW      = $clog2(MAX_DIM + 1)
) (
  input  logic [CFG_W-1:0] grid_width,
  input  logic [CFG_W-1:0] grid_height,
  input  logic             rewind,
  input  logic [2:0]       phase,
  input  logic [DW-1:0]    col,
  input  logic [DW-1:0]    row,
  input  logic [IDX_W-1:0] vbase,
  input  logic [IDX_W-1:0] ebase,
  input  logic             tri2,
  output logic [2:0]       phase_nxt,
  output logic [DW-1:0]    col_nxt,
  output logic [DW-1:0]    row_nxt,
  output logic [IDX_W-1:0] vbase_nxt,
  output logic [IDX_W-1:0] ebase_nxt,
  output logic             tri2_nxt,
  output gmeti_res_t       res
);

  logic [DW-1:0]    w, h, xd, yd;
  logic [IDX_W-1:0] w_i, xd_i, stride, two_xd1;
  logic [2:0]       c_phase;
  logic [DW-1:0]    c_col, c_row, col_inc, row_inc;
  logic [IDX_W-1:0] c_vb, c_eb, col_i;
  logic             c_tri2;
  logic             xd_zero, row_end;

  // Clamp the dimensions: zero counts as one, oversize as MAX_DIM.
  always_comb begin
    if (grid_width == '0) begin
      w = DW'(1);
    end else if (32'(grid_width) > MAX_DIM) begin
      w = DW'(MAX_DIM);
    end else begin
      w = DW'(grid_width);
    end
    if (grid_height == '0) begin
      h = DW'(1);
    end else if (32'(grid_height) > MAX_DIM) begin
      h = DW'(MAX_DIM);
    end else begin
      h = DW'(grid_height);
    end
  end

  assign xd      = w - DW'(1);
  assign yd      = h - DW'(1);
  assign xd_zero = (xd == '0);
  assign w_i     = IDX_W'(w);
  assign xd_i    = IDX_W'(xd);
  assign two_xd1 = (xd_i << 1) + IDX_W'(1);
  assign stride  = two_xd1 + xd_i;

  // Position to emit from: the settled start of the mesh on a rewind.
  always_comb begin
    if (rewind) begin
      c_col  = '0;
      c_row  = '0;
      c_vb   = '0;
      c_eb   = '0;
      c_tri2 = 1'b0;
      if (yd == '0) begin
        c_phase = xd_zero ? PH_DONE : PH_BOTTOM;
      end else begin
        c_phase = xd_zero ? PH_VERT : PH_HORIZ;
      end
    end else begin
      c_phase = phase;
      c_col   = col;
      c_row   = row;
      c_vb    = vbase;
      c_eb    = ebase;
      c_tri2  = tri2;
    end
  end

  assign col_inc = c_col + DW'(1);
  assign row_inc = c_row + DW'(1);
  assign col_i   = IDX_W'(c_col);
  assign row_end = (row_inc >= yd);

  always_comb begin
    res           = '0;
    res.valid_res = 1'b1;
    phase_nxt     = c_phase;
    col_nxt       = col_inc;
    row_nxt       = c_row;
    vbase_nxt     = c_vb;
    ebase_nxt     = c_eb;
    tri2_nxt      = c_tri2;
    case (c_phase)
      PH_HORIZ, PH_BOTTOM: begin
        res.idx_a = c_vb + col_i;
        res.idx_b = c_vb + col_i + IDX_W'(1);
        if (col_inc >= xd) begin
          col_nxt = '0;
          if (c_phase == PH_HORIZ) begin
            phase_nxt = PH_VERT;
          end else begin
            // bottom row done: restart walk for triangles, or finish if there is one row
            row_nxt   = '0;
            vbase_nxt = '0;
            ebase_nxt = '0;
            tri2_nxt  = 1'b0;
            phase_nxt = (yd == '0) ? PH_DONE : PH_TRI;
          end
        end
      end
      PH_VERT: begin
        res.idx_a = c_vb + col_i;
        res.idx_b = c_vb + w_i + col_i;
        if (col_inc >= w) begin
          col_nxt = '0;
          if (!xd_zero) begin
            phase_nxt = PH_DIAG;
          end else begin
            // no diagonals in a single column: next row at once
            row_nxt   = row_inc;
            vbase_nxt = c_vb + w_i;
            ebase_nxt = c_eb + stride;
            phase_nxt = row_end ? PH_DONE : PH_VERT;
          end
        end
      end
      PH_DIAG: begin
        res.idx_a = c_vb + col_i + IDX_W'(1);
        res.idx_b = c_vb + w_i + col_i;
        if (col_inc >= xd) begin
          col_nxt   = '0;
          row_nxt   = row_inc;
          vbase_nxt = c_vb + w_i;
          ebase_nxt = c_eb + stride;
          phase_nxt = row_end ? PH_BOTTOM : PH_HORIZ;
        end
      end
      PH_TRI: begin
        res.kind = 1'b1;
        if (!c_tri2) begin
          res.idx_a = c_eb + col_i;
          res.idx_b = c_eb + two_xd1 + col_i;
          res.idx_c = c_eb + xd_i + col_i;
          tri2_nxt  = 1'b1;
          col_nxt   = c_col;
        end else begin
          res.idx_a = c_eb + xd_i + col_i + IDX_W'(1);
          res.idx_b = c_eb + stride + col_i;
          res.idx_c = c_eb + two_xd1 + col_i;
          tri2_nxt  = 1'b0;
          if (col_inc >= xd) begin
            col_nxt   = '0;
            row_nxt   = row_inc;
            ebase_nxt = c_eb + stride;
            phase_nxt = row_end ? PH_DONE : PH_TRI;
          end
        end
      end
      default: begin
        // finished mesh: hold position, emit an empty result
        res       = '0;
        phase_nxt = PH_DONE;
        col_nxt   = c_col;
      end
    endcase
    res.last = res.valid_res && (phase_nxt == PH_DONE);
  end

endmodule

@@ hw/rtl/grid_mesh_edge_triangle_indexer.sv @@
// Top level of the grid mesh indexer: registers, handshakes and checks.
//
//   channel  dir  payload                                  accepted when
//   in_ch    in   restart                                  valid && ready
//   out_ch   out  valid_res kind idx_a idx_b idx_c last    valid && ready
//   cfg_ch   in   addr (0 width, 1 height), data           valid && ready
//
// One request in, one result out; the walk position, rewind flag, result register
// and its valid flag are the only state updated per request, so requests flow at
// one per clock unless out_ch stalls; a result shows the cycle after its request.
// in_ch.ready drops only while the result register is full and out_ch stalls.
// rst_n (synchronous) rewinds the walk and loads both dimensions with 128.
`include "grid_mesh_edge_triangle_indexer_defines.svh"

module grid_mesh_edge_triangle_indexer import gmeti_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  gmeti_in_if.sink     in_ch,
  gmeti_out_if.source  out_ch,
  gmeti_cfg_if.sink    cfg_ch
);

  localparam int DW = $clog2(MAX_DIM + 1);

  logic [CFG_W-1:0] grid_width_r, grid_height_r;
  logic             rewind_r;
  logic [2:0]       phase_r, phase_nxt;
  logic [DW-1:0]    col_r, col_nxt, row_r, row_nxt;
  logic [IDX_W-1:0] vbase_r, vbase_nxt, ebase_r, ebase_nxt;
  logic             tri2_r, tri2_nxt;
  gmeti_res_t       res_r, res_nxt;
  logic             out_vld_r;
  logic             in_acc, cfg_acc, cfg_hit;

  assign in_ch.ready  = !out_vld_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_acc      = cfg_ch.valid;
  assign cfg_hit      = cfg_acc && ((cfg_ch.addr == REG_GRID_WIDTH) ||
                                    (cfg_ch.addr == REG_GRID_HEIGHT));

  gmeti_step #(
    .MAX_DIM (MAX_DIM),
    .DW      (DW)
  ) u_step (
    .grid_width  (grid_width_r),
    .grid_height (grid_height_r),
    .rewind      (rewind_r || in_ch.restart),
    .phase       (phase_r),
    .col         (col_r),
    .row         (row_r),
    .vbase       (vbase_r),
    .ebase       (ebase_r),
    .tri2        (tri2_r),
    .phase_nxt   (phase_nxt),
    .col_nxt     (col_nxt),
    .row_nxt     (row_nxt),
    .vbase_nxt   (vbase_nxt),
    .ebase_nxt   (ebase_nxt),
    .tri2_nxt    (tri2_nxt),
    .res         (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= CFG_DIM_RESET;
      grid_height_r <= CFG_DIM_RESET;
      rewind_r      <= 1'b1;
      phase_r       <= PH_HORIZ;
      col_r         <= '0;
      row_r         <= '0;
      vbase_r       <= '0;
      ebase_r       <= '0;
      tri2_r        <= 1'b0;
      out_vld_r     <= 1'b0;
    end else begin
      if (cfg_hit) begin
        if (cfg_ch.addr == REG_GRID_WIDTH) begin
          grid_width_r <= cfg_ch.data;
        end else begin
          grid_height_r <= cfg_ch.data;
        end
      end
      if (in_acc) begin
        phase_r <= phase_nxt;
        col_r   <= col_nxt;
        row_r   <= row_nxt;
        vbase_r <= vbase_nxt;
        ebase_r <= ebase_nxt;
        tri2_r  <= tri2_nxt;
      end
      // a register write rewinds the walk; it wins over a request
      if (cfg_hit) begin
        rewind_r <= 1'b1;
      end else if (in_acc) begin
        rewind_r <= 1'b0;
      end
      if (in_acc) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.valid_res = res_r.valid_res;
  assign out_ch.kind      = res_r.kind;
  assign out_ch.idx_a     = res_r.idx_a;
  assign out_ch.idx_b     = res_r.idx_b;
  assign out_ch.idx_c     = res_r.idx_c;
  assign out_ch.last      = res_r.last;

  `GMETI_ASSERT_NOW(a_last_is_element, out_vld_r && res_r.last, res_r.valid_res)
  `GMETI_ASSERT_NOW(a_edge_no_third, out_vld_r && res_r.valid_res && !res_r.kind,
                    res_r.idx_c == '0)
  `GMETI_ASSERT_NEXT(a_done_stays_empty,
                     in_acc && !in_ch.restart && !rewind_r && (phase_r == PH_DONE) && !cfg_hit,
                     !res_r.valid_res && (phase_r == PH_DONE))
  `GMETI_ASSERT_NEXT(a_cfg_rewinds, cfg_hit, rewind_r)
  `GMETI_ASSERT_NEXT(a_last_ends_walk, in_acc && res_nxt.last && !cfg_hit,
                     phase_r == PH_DONE)

endmodule
